@@ rtl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// Types, codes and lexing step functions shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int MAX_LINE = 4096;
    localparam int POS_W    = $clog2(MAX_LINE);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE - 1);
    localparam int NRES     = 4;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        K_WORD, K_ASSIGN, K_PIPE, K_OR, K_BG, K_AND, K_SEMI, K_LPAREN,
        K_RPAREN, K_OUT, K_APPEND, K_IN, K_ERR, K_ERRTOOUT, K_END
    } kind_t;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_SQ, M_DQ, M_BAR, M_AMP, M_GT, M_2GT, M_2GTAMP
    } mode_t;

    typedef enum logic [1:0] { H_NONE, H_TWO, H_BSL } held_t;
    typedef enum logic [1:0] { A_EMPTY, A_NAME, A_YES, A_NO } atrack_t;

    typedef struct packed {
        mode_t            mode;
        held_t            held;
        logic [POS_W-1:0] tstart;
        atrack_t          atrack;
    } lex_st_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_val;
        logic        has;
        logic        done;
        logic [11:0] start;
    } res_t;

    typedef struct packed {
        res_t [NRES-1:0] items;
        logic [2:0]      cnt;
    } bundle_t;

    typedef struct packed {
        lex_st_t s;
        logic    rep;
        logic    emit;
        res_t    r;
    } feed_t;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_break(logic [7:0] c);
        return c == "|" || c == "&" || c == ";" || c == ">" || c == "<" ||
               c == "(" || c == ")";
    endfunction

    function automatic atrack_t atrack_next(atrack_t a, logic [7:0] c);
        atrack_t n;
        n = a;
        if (a == A_EMPTY)
            n = (is_alpha(c) || c == "_") ? A_NAME : A_NO;
        else if (a == A_NAME)
        begin
            if (c == "=")
                n = A_YES;
            else if (!(is_alpha(c) || is_digit(c) || c == "_"))
                n = A_NO;
        end
        return n;
    endfunction

    function automatic res_t mk_byte(logic [7:0] c);
        res_t r;
        r = '0;
        r.kind = K_WORD;
        r.byte_val = c;
        r.has = 1'b1;
        return r;
    endfunction

    function automatic res_t mk_done(kind_t k, logic [POS_W-1:0] p);
        res_t r;
        r = '0;
        r.kind = k;
        r.done = 1'b1;
        r.start = 12'(p);
        return r;
    endfunction

    function automatic kind_t word_kind(logic cfg, atrack_t a);
        return (cfg && a == A_YES) ? K_ASSIGN : K_WORD;
    endfunction

    function automatic bundle_t push(bundle_t b, res_t r);
        bundle_t n;
        n = b;
        if (b.cnt != 3'(NRES))
        begin
            n.items[b.cnt[1:0]] = r;
            n.cnt = b.cnt + 3'd1;
        end
        return n;
    endfunction

    // one lexing step on one byte; rep asks for the same byte again
    function automatic feed_t feed(lex_st_t s, logic [7:0] c, logic [POS_W-1:0] p,
                                   logic cfg);
        feed_t f;
        logic [POS_W-1:0] prev;
        f = '0;
        f.s = s;
        prev = (p == '0) ? '0 : p - POS_W'(1);
        case (s.mode)
            M_BAR:
            begin
                f.emit = 1'b1; f.s.mode = M_IDLE;
                f.r = mk_done((c == "|") ? K_OR : K_PIPE, s.tstart);
                f.rep = (c != "|");
            end
            M_AMP:
            begin
                f.emit = 1'b1; f.s.mode = M_IDLE;
                f.r = mk_done((c == "&") ? K_AND : K_BG, s.tstart);
                f.rep = (c != "&");
            end
            M_GT:
            begin
                f.emit = 1'b1; f.s.mode = M_IDLE;
                f.r = mk_done((c == ">") ? K_APPEND : K_OUT, s.tstart);
                f.rep = (c != ">");
            end
            M_2GT:
            begin
                if (c == "&")
                    f.s.mode = M_2GTAMP;
                else
                begin
                    f.emit = 1'b1; f.s.mode = M_IDLE; f.rep = 1'b1;
                    f.r = mk_done(K_ERR, s.tstart);
                end
            end
            M_2GTAMP:
            begin
                f.emit = 1'b1;
                if (c == "1")
                begin
                    f.r = mk_done(K_ERRTOOUT, s.tstart);
                    f.s.mode = M_IDLE;
                end
                else
                begin
                    // fall back: close 2>, then lex the held '&'
                    f.r = mk_done(K_ERR, s.tstart);
                    f.s.tstart = prev;
                    f.s.mode = M_AMP;
                    f.rep = 1'b1;
                end
            end
            M_WORD:
            begin
                if (s.held == H_TWO)
                begin
                    f.s.held = H_NONE;
                    f.emit = 1'b1;
                    if (c == ">")
                    begin
                        f.r = mk_done(word_kind(cfg, s.atrack), s.tstart);
                        f.s.tstart = prev;
                        f.s.mode = M_2GT;
                    end
                    else
                    begin
                        f.s.atrack = atrack_next(s.atrack, "2");
                        f.r = mk_byte("2");
                        f.rep = 1'b1;
                    end
                end
                else if (s.held == H_BSL)
                begin
                    f.s.held = H_NONE; f.emit = 1'b1;
                    f.s.atrack = atrack_next(s.atrack, c);
                    f.r = mk_byte(c);
                end
                else if (is_space(c) || is_break(c))
                begin
                    f.emit = 1'b1; f.s.mode = M_IDLE; f.s.held = H_NONE;
                    f.r = mk_done(word_kind(cfg, s.atrack), s.tstart);
                    f.rep = is_break(c);
                end
                else if (c == "2")
                    f.s.held = H_TWO;
                else if (c == "'")
                    f.s.mode = M_SQ;
                else if (c == "\"")
                    f.s.mode = M_DQ;
                else if (c == "\\")
                    f.s.held = H_BSL;
                else
                begin
                    f.emit = 1'b1;
                    f.s.atrack = atrack_next(s.atrack, c);
                    f.r = mk_byte(c);
                end
            end
            M_SQ:
            begin
                if (c == "'")
                    f.s.mode = M_WORD;
                else
                begin
                    f.emit = 1'b1;
                    f.s.atrack = atrack_next(s.atrack, c);
                    f.r = mk_byte(c);
                end
            end
            M_DQ:
            begin
                if (s.held == H_BSL)
                begin
                    f.s.held = H_NONE; f.emit = 1'b1;
                    if (c == "\"" || c == "\\" || c == "$")
                    begin
                        f.s.atrack = atrack_next(s.atrack, c);
                        f.r = mk_byte(c);
                    end
                    else
                    begin
                        f.s.atrack = atrack_next(s.atrack, "\\");
                        f.r = mk_byte("\\");
                        f.rep = 1'b1;
                    end
                end
                else if (c == "\"")
                    f.s.mode = M_WORD;
                else if (c == "\\")
                    f.s.held = H_BSL;
                else
                begin
                    f.emit = 1'b1;
                    f.s.atrack = atrack_next(s.atrack, c);
                    f.r = mk_byte(c);
                end
            end
            default:
            begin
                f.s.mode = M_IDLE;
                f.s.held = H_NONE;
                if (s.held == H_TWO)
                begin
                    if (c == ">")
                        f.s.mode = M_2GT;
                    else
                    begin
                        // held '2' opens a word at its own offset
                        f.s.mode = M_WORD;
                        f.s.atrack = atrack_next(A_EMPTY, "2");
                        f.emit = 1'b1;
                        f.r = mk_byte("2");
                        f.rep = 1'b1;
                    end
                end
                else if (!is_space(c))
                begin
                    case (c)
                        "|":
                        begin
                            f.s.tstart = p; f.s.mode = M_BAR;
                        end
                        "&":
                        begin
                            f.s.tstart = p; f.s.mode = M_AMP;
                        end
                        ">":
                        begin
                            f.s.tstart = p; f.s.mode = M_GT;
                        end
                        ";":
                        begin
                            f.emit = 1'b1; f.r = mk_done(K_SEMI, p);
                        end
                        "(":
                        begin
                            f.emit = 1'b1; f.r = mk_done(K_LPAREN, p);
                        end
                        ")":
                        begin
                            f.emit = 1'b1; f.r = mk_done(K_RPAREN, p);
                        end
                        "<":
                        begin
                            f.emit = 1'b1; f.r = mk_done(K_IN, p);
                        end
                        "2":
                        begin
                            f.s.tstart = p; f.s.held = H_TWO;
                        end
                        default:
                        begin
                            f.s.tstart = p; f.s.mode = M_WORD;
                            f.s.atrack = A_EMPTY; f.rep = 1'b1;
                        end
                    endcase
                end
            end
        endcase
        return f;
    endfunction

endpackage

@@ rtl/shell_command_tokenizer.sv @@
// ----------------------------------------------------------------------------
// shell_command_tokenizer
// Streaming shell command-line lexer with decoupled lexer and output sides.
// ----------------------------------------------------------------------------
// One input beat (a byte or an end-of-line mark) is lexed per cycle unless the
// queue is full; its results (zero to three) go into a four-deep bundle queue,
// and the output side hands them out one per cycle while out_ready is high.
// Sustained input rate is one beat per cycle while beats average at most one
// result each; extra results go out in turn and the queue absorbs bursts.
module shell_command_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_of_line,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [7:0]  content_byte,
    output logic        has_byte,
    output logic        token_done,
    output logic [11:0] start_pos,
    output logic        last_result
);

    sct_pkg::bundle_t bundle, head;
    sct_pkg::res_t    item;
    logic             step, full, empty, pop;

    assign in_ready = !full;
    assign step     = in_valid && in_ready;

    sct_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .step        (step),
        .ch          (ch),
        .end_of_line (end_of_line),
        .bundle      (bundle)
    );

    sct_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step && bundle.cnt != 3'd0),
        .wdata (bundle),
        .pop   (pop),
        .rdata (head),
        .full  (full),
        .empty (empty)
    );

    sct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .item      (item),
        .last      (last_result)
    );

    assign token_kind   = item.kind;
    assign content_byte = item.byte_val;
    assign has_byte     = item.has;
    assign token_done   = item.done;
    assign start_pos    = item.start;

endmodule

@@ rtl/sct_front.sv @@
// ----------------------------------------------------------------------------
// sct_front
// Lexer state and classification: turns one beat into a bundle of results.
// ----------------------------------------------------------------------------
module sct_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              step,
    input  logic [7:0]        ch,
    input  logic              end_of_line,
    output sct_pkg::bundle_t  bundle
);

    sct_pkg::lex_st_t           st_reg, st_next;
    logic [sct_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       cfg_reg;

    always_comb
    begin
        sct_pkg::lex_st_t          s;
        sct_pkg::feed_t            f;
        sct_pkg::bundle_t          b;
        logic [sct_pkg::POS_W-1:0] prev;
        logic                      go;
        s = st_reg;
        f = '0;
        b = '0;
        go = 1'b1;
        prev = (pos_reg == '0) ? '0 : pos_reg - sct_pkg::POS_W'(1);
        pos_next = pos_reg;
        if (end_of_line)
        begin
            case (s.mode)
                sct_pkg::M_BAR:
                    b = sct_pkg::push(b, sct_pkg::mk_done(sct_pkg::K_PIPE, s.tstart));
                sct_pkg::M_AMP:
                    b = sct_pkg::push(b, sct_pkg::mk_done(sct_pkg::K_BG, s.tstart));
                sct_pkg::M_GT:
                    b = sct_pkg::push(b, sct_pkg::mk_done(sct_pkg::K_OUT, s.tstart));
                sct_pkg::M_2GT:
                    b = sct_pkg::push(b, sct_pkg::mk_done(sct_pkg::K_ERR, s.tstart));
                sct_pkg::M_2GTAMP:
                begin
                    b = sct_pkg::push(b, sct_pkg::mk_done(sct_pkg::K_ERR, s.tstart));
                    b = sct_pkg::push(b, sct_pkg::mk_done(sct_pkg::K_BG, prev));
                end
                sct_pkg::M_WORD, sct_pkg::M_SQ, sct_pkg::M_DQ:
                begin
                    if (s.held == sct_pkg::H_TWO)
                    begin
                        s.atrack = sct_pkg::atrack_next(s.atrack, "2");
                        b = sct_pkg::push(b, sct_pkg::mk_byte("2"));
                    end
                    else if (s.held == sct_pkg::H_BSL && s.mode == sct_pkg::M_DQ)
                    begin
                        s.atrack = sct_pkg::atrack_next(s.atrack, "\\");
                        b = sct_pkg::push(b, sct_pkg::mk_byte("\\"));
                    end
                    b = sct_pkg::push(b, sct_pkg::mk_done(
                            sct_pkg::word_kind(cfg_reg, s.atrack), s.tstart));
                end
                default:
                begin
                    if (s.held == sct_pkg::H_TWO)
                    begin
                        s.atrack = sct_pkg::atrack_next(sct_pkg::A_EMPTY, "2");
                        b = sct_pkg::push(b, sct_pkg::mk_byte("2"));
                        b = sct_pkg::push(b, sct_pkg::mk_done(
                                sct_pkg::word_kind(cfg_reg, s.atrack), s.tstart));
                    end
                end
            endcase
            b = sct_pkg::push(b, sct_pkg::mk_done(sct_pkg::K_END, pos_reg));
            s.mode = sct_pkg::M_IDLE;
            s.held = sct_pkg::H_NONE;
            s.tstart = '0;
            s.atrack = sct_pkg::A_EMPTY;
            pos_next = '0;
        end
        else
        begin
            // a byte is revisited at most five times, at most one result per visit
            for (int i = 0; i < 5; i++)
            begin
                if (go)
                begin
                    f = sct_pkg::feed(s, ch, pos_reg, cfg_reg);
                    s = f.s;
                    if (f.emit)
                        b = sct_pkg::push(b, f.r);
                    go = f.rep;
                end
            end
            if (pos_reg != sct_pkg::POS_MAX)
                pos_next = pos_reg + sct_pkg::POS_W'(1);
        end
        st_next = s;
        bundle = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            pos_reg <= '0;
            cfg_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (step)
            begin
                st_reg  <= st_next;
                pos_reg <= pos_next;
            end
        end
    end

endmodule

@@ rtl/sct_queue.sv @@
// ----------------------------------------------------------------------------
// sct_queue
// Short FIFO of result bundles between the lexer and the output serializer.
// ----------------------------------------------------------------------------
module sct_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sct_pkg::bundle_t  wdata,
    input  logic              pop,
    output sct_pkg::bundle_t  rdata,
    output logic              full,
    output logic              empty
);

    sct_pkg::bundle_t                mem [sct_pkg::QDEPTH];
    logic [sct_pkg::QPTR_W-1:0]      wp_reg, rp_reg;
    logic [sct_pkg::QPTR_W:0]        cnt_reg;

    assign full  = (cnt_reg == (sct_pkg::QPTR_W+1)'(sct_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + sct_pkg::QPTR_W'(1);
            if (pop)
                rp_reg <= rp_reg + sct_pkg::QPTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (sct_pkg::QPTR_W+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (sct_pkg::QPTR_W+1)'(1);
        end
    end

endmodule

@@ rtl/sct_back.sv @@
// ----------------------------------------------------------------------------
// sct_back
// Output serializer: hands out the results of a bundle one beat at a time.
// ----------------------------------------------------------------------------
module sct_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sct_pkg::bundle_t  head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output sct_pkg::res_t     item,
    output logic              last
);

    logic [1:0] idx_reg, idx_next;

    assign out_valid = !empty;
    assign item      = head.items[idx_reg];
    assign last      = ({1'b0, idx_reg} == head.cnt - 3'd1);
    assign pop       = out_valid && out_ready && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_valid && out_ready)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

@@ rtl/sct_checker.sv @@
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks on the tokenizer output stream.
// ----------------------------------------------------------------------------
module sct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  token_kind,
    input logic        has_byte,
    input logic        token_done,
    input logic [11:0] start_pos,
    input logic        last_result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before beat taken");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_byte != token_done))
        else $error("beat must be exactly one of content or done");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == sct_pkg::K_END |-> token_done && last_result)
        else $error("end token must close its step");

    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte |-> token_kind == sct_pkg::K_WORD && start_pos == 12'd0)
        else $error("content beat carries kind or start");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .token_kind  (token_kind),
    .has_byte    (has_byte),
    .token_done  (token_done),
    .start_pos   (start_pos),
    .last_result (last_result)
);
